// File: sv/vpps_pkg.sv
package vpps_pkg;

   // default component width of the velocity and field vectors
   localparam int COMP_W_DEF = 16;

   // number of vector components, one lane each
   localparam int NUM_LANES = 3;

endpackage

// File: sv/vpps_if.sv
interface vpps_req_if #(parameter int W = vpps_pkg::COMP_W_DEF);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] vel_x;
   logic signed [W-1:0] vel_y;
   logic signed [W-1:0] vel_z;
   logic signed [W-1:0] field_x;
   logic signed [W-1:0] field_y;
   logic signed [W-1:0] field_z;

   modport source (output valid, vel_x, vel_y, vel_z, field_x, field_y, field_z,
                   input ready);
   modport sink (input valid, vel_x, vel_y, vel_z, field_x, field_y, field_z,
                 output ready);
endinterface

interface vpps_rsp_if #(parameter int W = vpps_pkg::COMP_W_DEF);
   logic              valid;
   logic              ready;
   logic signed [W:0] par_x;
   logic signed [W:0] par_y;
   logic signed [W:0] par_z;
   logic signed [W:0] perp_x;
   logic signed [W:0] perp_y;
   logic signed [W:0] perp_z;
   logic              field_zero;

   modport source (output valid, par_x, par_y, par_z, perp_x, perp_y, perp_z, field_zero,
                   input ready);
   modport sink (input valid, par_x, par_y, par_z, perp_x, perp_y, perp_z, field_zero,
                 output ready);
endinterface

// File: sv/vector_parallel_perpendicular_split.sv
// Throughput: one transaction per cycle; six front stages form the cross products,
// then each component lane runs a COMPONENT_WIDTH+1 stage restoring divider.
// The whole pipeline holds while a response waits for rsp ready.
// Reset (synchronous, active high) clears the pipeline valid bits; data is not reset.
module vector_parallel_perpendicular_split #(
   parameter int COMPONENT_WIDTH = vpps_pkg::COMP_W_DEF
) (
   input logic    clock,
   input logic    reset,
   vpps_req_if.sink   req_ch,
   vpps_rsp_if.source rsp_ch
);
   import vpps_pkg::*;

   localparam int W  = COMPONENT_WIDTH;
   localparam int QB = W + 1;
   localparam int L  = W + 8;

   logic                adv;
   logic [L-1:0]        vld_ff;
   logic signed [W-1:0] vel [NUM_LANES];
   logic signed [W-1:0] fld [NUM_LANES];
   logic [3*W:0]        num_mag [NUM_LANES];
   logic                num_neg [NUM_LANES];
   logic [2*W-1:0]      den;
   logic signed [W-1:0] vel_f [NUM_LANES];
   logic                zero_f;
   logic signed [W:0]   par [NUM_LANES];
   logic signed [W:0]   perp [NUM_LANES];
   logic [QB-1:0]       zd_ff;
   logic signed [W:0]   par_ff [NUM_LANES];
   logic signed [W:0]   perp_ff [NUM_LANES];
   logic                zero_ff;

   assign adv          = !vld_ff[L-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   assign vel[0] = req_ch.vel_x;
   assign vel[1] = req_ch.vel_y;
   assign vel[2] = req_ch.vel_z;
   assign fld[0] = req_ch.field_x;
   assign fld[1] = req_ch.field_y;
   assign fld[2] = req_ch.field_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[L-2:0], req_ch.valid};
      end
   end

   vpps_front #(.W(W)) u_front (
      .clock   (clock),
      .adv     (adv),
      .vel     (vel),
      .fld     (fld),
      .num_mag (num_mag),
      .num_neg (num_neg),
      .den     (den),
      .vel_o   (vel_f),
      .zero    (zero_f)
   );

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      vpps_div_lane #(.W(W)) u_lane (
         .clock   (clock),
         .adv     (adv),
         .num_mag (num_mag[i]),
         .num_neg (num_neg[i]),
         .den     (den),
         .vel     (vel_f[i]),
         .zero    (zero_f),
         .par     (par[i]),
         .perp    (perp[i])
      );
   end

   // merge the lanes into the response register; zero flag rides alongside the dividers
   always_ff @(posedge clock) begin
      if (adv) begin
         zd_ff   <= {zd_ff[QB-2:0], zero_f};
         zero_ff <= zd_ff[QB-1];
         par_ff  <= par;
         perp_ff <= perp;
      end
   end

   assign rsp_ch.valid      = vld_ff[L-1];
   assign rsp_ch.par_x      = par_ff[0];
   assign rsp_ch.par_y      = par_ff[1];
   assign rsp_ch.par_z      = par_ff[2];
   assign rsp_ch.perp_x     = perp_ff[0];
   assign rsp_ch.perp_y     = perp_ff[1];
   assign rsp_ch.perp_z     = perp_ff[2];
   assign rsp_ch.field_zero = zero_ff;

   a_zero_perp: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.field_zero |->
         rsp_ch.perp_x == '0 && rsp_ch.perp_y == '0 && rsp_ch.perp_z == '0)
      else $error("zero field with nonzero perpendicular part");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && !req_ch.ready == !rsp_ch.ready)
      else $error("stalled response dropped");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid right after reset");

endmodule

// File: sv/vpps_front.sv
module vpps_front #(
   parameter int W = vpps_pkg::COMP_W_DEF
) (
   input  logic                  clock,
   input  logic                  adv,
   input  logic signed [W-1:0]   vel [vpps_pkg::NUM_LANES],
   input  logic signed [W-1:0]   fld [vpps_pkg::NUM_LANES],
   output logic [3*W:0]          num_mag [vpps_pkg::NUM_LANES],
   output logic                  num_neg [vpps_pkg::NUM_LANES],
   output logic [2*W-1:0]        den,
   output logic signed [W-1:0]   vel_o [vpps_pkg::NUM_LANES],
   output logic                  zero
);
   import vpps_pkg::*;

   localparam int PW = 2 * W;
   localparam int CW = 2 * W + 1;
   localparam int DW = 3 * W + 2;

   logic signed [W-1:0]  v1_ff [NUM_LANES], v2_ff [NUM_LANES], v3_ff [NUM_LANES];
   logic signed [W-1:0]  v4_ff [NUM_LANES], v5_ff [NUM_LANES], v6_ff [NUM_LANES];
   logic signed [W-1:0]  b1_ff [NUM_LANES], b2_ff [NUM_LANES], b3_ff [NUM_LANES];
   logic signed [PW-1:0] pa_ff [NUM_LANES], pb_ff [NUM_LANES], sq_ff [NUM_LANES];
   logic signed [CW-1:0] c_ff [NUM_LANES];
   logic signed [DW-1:0] da_ff [NUM_LANES], db_ff [NUM_LANES], d_ff [NUM_LANES];
   logic [DW-2:0]        mag_ff [NUM_LANES];
   logic                 neg_ff [NUM_LANES];
   logic [PW-1:0]        msq3_ff, msq4_ff, msq5_ff, msq6_ff;
   logic [PW-1:0]        msq_in;

   assign msq_in = PW'(sq_ff[0]) + PW'(sq_ff[1]) + PW'(sq_ff[2]);

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;

      always_ff @(posedge clock) begin
         if (adv) begin
            v1_ff[i]  <= vel[i];
            b1_ff[i]  <= fld[i];
            // cross product terms of vel x field
            pa_ff[i]  <= PW'(v1_ff[J]) * PW'(b1_ff[K]);
            pb_ff[i]  <= PW'(v1_ff[K]) * PW'(b1_ff[J]);
            sq_ff[i]  <= PW'(b1_ff[i]) * PW'(b1_ff[i]);
            v2_ff[i]  <= v1_ff[i];
            b2_ff[i]  <= b1_ff[i];
            c_ff[i]   <= CW'(pa_ff[i]) - CW'(pb_ff[i]);
            v3_ff[i]  <= v2_ff[i];
            b3_ff[i]  <= b2_ff[i];
            // field x c
            da_ff[i]  <= DW'(b3_ff[J]) * DW'(c_ff[K]);
            db_ff[i]  <= DW'(b3_ff[K]) * DW'(c_ff[J]);
            v4_ff[i]  <= v3_ff[i];
            d_ff[i]   <= da_ff[i] - db_ff[i];
            v5_ff[i]  <= v4_ff[i];
            neg_ff[i] <= d_ff[i][DW-1];
            mag_ff[i] <= d_ff[i][DW-1] ? (DW-1)'(-d_ff[i]) : (DW-1)'(d_ff[i]);
            v6_ff[i]  <= v5_ff[i];
         end
      end

      assign num_mag[i] = mag_ff[i];
      assign num_neg[i] = neg_ff[i];
      assign vel_o[i]   = v6_ff[i];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         msq3_ff <= msq_in;
         msq4_ff <= msq3_ff;
         msq5_ff <= msq4_ff;
         msq6_ff <= msq5_ff;
      end
   end

   assign den  = msq6_ff;
   assign zero = (msq6_ff == '0);

endmodule

// File: sv/vpps_div_lane.sv
module vpps_div_lane #(
   parameter int W = vpps_pkg::COMP_W_DEF
) (
   input  logic                clock,
   input  logic                adv,
   input  logic [3*W:0]        num_mag,
   input  logic                num_neg,
   input  logic [2*W-1:0]      den,
   input  logic signed [W-1:0] vel,
   input  logic                zero,
   output logic signed [W:0]   par,
   output logic signed [W:0]   perp
);
   import vpps_pkg::*;

   localparam int NB = 3 * W + 1;
   localparam int QB = W + 1;

   logic [NB-1:0]       rem_ff [QB];
   logic [QB-1:0]       q_ff   [QB];
   logic [2*W-1:0]      den_ff [QB];
   logic                neg_ff [QB];
   logic                zero_ff [QB];
   logic signed [W-1:0] v_ff   [QB];
   logic signed [W:0]   quo;

   // one quotient bit per stage, most significant first
   for (genvar s = 0; s < QB; s++) begin : g_stage
      localparam int T = QB - 1 - s;
      logic [NB-1:0]       rem_src;
      logic [QB-1:0]       q_src;
      logic [2*W-1:0]      den_src;
      logic                neg_src, zero_src;
      logic signed [W-1:0] v_src;
      logic [NB-1:0]       dsh;
      logic                take;

      if (s == 0) begin : g_first
         assign rem_src  = num_mag;
         assign q_src    = '0;
         assign den_src  = den;
         assign neg_src  = num_neg;
         assign zero_src = zero;
         assign v_src    = vel;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign q_src    = q_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign neg_src  = neg_ff[s-1];
         assign zero_src = zero_ff[s-1];
         assign v_src    = v_ff[s-1];
      end

      assign dsh  = NB'(den_src) << T;
      assign take = (rem_src >= dsh);

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= take ? rem_src - dsh : rem_src;
            q_ff[s]    <= {q_src[QB-2:0], take};
            den_ff[s]  <= den_src;
            neg_ff[s]  <= neg_src;
            zero_ff[s] <= zero_src;
            v_ff[s]    <= v_src;
         end
      end
   end

   assign quo  = neg_ff[QB-1] ? -$signed(q_ff[QB-1]) : $signed(q_ff[QB-1]);
   assign perp = zero_ff[QB-1] ? '0 : quo;
   assign par  = (W+1)'((W+2)'(v_ff[QB-1]) - (W+2)'(perp));

endmodule
